@@ sv/tilt_compensated_heading_top_defines.svh @@
// ----------------------------------------------------------------------------
// tilt compensated heading - assertion macros
// clocked, reset-qualified concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_TOP_DEFINES_SVH
`define TILT_COMPENSATED_HEADING_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tch assertion failed");
`define TCH_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`else
`define TCH_ASSERT(lbl, prop)
`define TCH_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

@@ sv/tch_pkg.sv @@
// ----------------------------------------------------------------------------
// tch_pkg
// widths, cordic constants and stage indexes for the heading pipeline
// ----------------------------------------------------------------------------
package tch_pkg;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int AW     = ANGLE_FRAC_BITS + 3;
    localparam int HEAD_W = ANGLE_FRAC_BITS + 2;
    localparam int SW     = SAMPLE_WIDTH;
    localparam int ITERS  = 30;
    localparam int ZW     = 35;                 // q30 angle incl. folding headroom
    localparam int CSW    = 32;                 // q30 sine and cosine
    localparam int PW     = SW + CSW;           // sample times q30
    localparam int VW     = SW + 34;            // horizontal components and growth
    localparam int VZW    = 32;                 // vectoring angle accumulator
    localparam int IN_W   = ((2 * AW + 3 * SW + 7) / 8) * 8;
    localparam int OUT_W  = ((HEAD_W + 7) / 8) * 8;

    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam int     HALF_OUT    =
        int'((Q30_HALF_PI + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS));

    // stage indexes
    localparam int S_FIX  = ITERS + 1;
    localparam int S_M1   = ITERS + 2;
    localparam int S_M2   = ITERS + 3;
    localparam int S_SUM  = ITERS + 4;
    localparam int S_PREP = ITERS + 5;
    localparam int S_OUT  = S_PREP + ITERS + 1;
    localparam int NSTG   = S_OUT + 1;

    localparam logic [31:0] ATAN_TAB [0:ITERS-1] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
        32'd31,        32'd15,        32'd7,         32'd3,         32'd1
    };

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_sc;

    typedef struct packed {
        logic signed [VW-1:0]  x;
        logic signed [VW-1:0]  y;
        logic signed [VZW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
    } t_mag;

    typedef struct packed {
        logic zf;       // horizontal x was zero
        logic ypos;
        logic yneg;
    } t_flags;
endpackage

@@ sv/tilt_compensated_heading_top.sv @@
// ----------------------------------------------------------------------------
// tilt_compensated_heading_top
// tilt compensated compass heading: cordic sine/cosine of pitch and roll,
// horizontal field projection, cordic vectoring arctangent of yh/xh
// ----------------------------------------------------------------------------
// channel  dir  payload                                         handshake
// s_axis   in   tdata: pitch, roll, mag_x, mag_y, mag_z          tvalid/tready
// m_axis   out  tdata: heading_angle (15b + pad), tuser: zero_div tvalid/tready
//
// one item per cycle while the output is not stalled
// 67 register stages: the two 30-step cordic pipelines plus 7 other stages
// a stall at the output freezes the whole pipeline, nothing is dropped
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
`include "tilt_compensated_heading_top_defines.svh"

module tilt_compensated_heading_top
    import tch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // pitch, roll, mag_x, mag_y, mag_z
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // heading_angle, zero pad
    output logic             o_m_axis_tuser    // zero_divisor
);
    localparam logic signed [ZW-1:0]     ZHALF = ZW'(Q30_HALF_PI);
    localparam logic signed [ZW-1:0]     ZPI   = ZW'(Q30_PI);
    localparam logic signed [HEAD_W-1:0] HHALF = HEAD_W'(HALF_OUT);
    // vectoring angle bound, the sum of the arctangent table
    localparam logic signed [HEAD_W-1:0] HMAX  = HEAD_W'(14281);

    function automatic t_sc sc_step(input t_sc a, input int sh, input logic [31:0] at);
        t_sc n;
        logic signed [ZW-1:0] atz;
        atz = ZW'(signed'(at));
        if (!a.z[ZW-1]) begin
            n.x = a.x - (a.y >>> sh);
            n.y = a.y + (a.x >>> sh);
            n.z = a.z - atz;
        end else begin
            n.x = a.x + (a.y >>> sh);
            n.y = a.y - (a.x >>> sh);
            n.z = a.z + atz;
        end
        return n;
    endfunction

    function automatic t_vec vec_step(input t_vec a, input int sh, input logic [31:0] at);
        t_vec n;
        logic signed [VZW-1:0] atz;
        atz = VZW'(signed'(at));
        if (!a.y[VW-1]) begin
            n.x = a.x + (a.y >>> sh);
            n.y = a.y - (a.x >>> sh);
            n.z = a.z + atz;
        end else begin
            n.x = a.x - (a.y >>> sh);
            n.y = a.y + (a.x >>> sh);
            n.z = a.z - atz;
        end
        return n;
    endfunction

    // angles beyond +/- pi/2 move by pi and flip sine and cosine
    function automatic logic [ZW:0] fold(input logic signed [AW-1:0] ang);
        logic signed [ZW-1:0] a;
        logic                 neg;
        a   = ZW'(ang) <<< (30 - ANGLE_FRAC_BITS);
        neg = 1'b0;
        if (a > ZHALF) begin
            a   = a - ZPI;
            neg = 1'b1;
        end else if (a < -ZHALF) begin
            a   = a + ZPI;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    logic            en;
    logic [NSTG-1:0] r_vld;

    t_sc  r_ps   [0:ITERS];
    t_sc  r_rs   [0:ITERS];
    logic r_pneg [0:ITERS];
    logic r_rneg [0:ITERS];
    t_mag r_mag  [0:ITERS];

    logic [ZW:0] n_pf, n_rf;

    logic signed [CSW-1:0]   r_sp, r_cp, r_sr, r_cr;
    t_mag                    r_mag_f, r_mag1;
    logic signed [2*CSW-1:0] r_srsp_p, r_srcp_p;
    logic signed [CSW-1:0]   r_cp1, r_sp1, r_cr1;
    logic signed [CSW-1:0]   n_srsp, n_srcp;
    logic signed [PW-1:0]    r_pa, r_pb, r_pc, r_pd, r_pe;
    logic signed [VW-1:0]    r_xh, r_yh;

    t_vec   r_v   [0:ITERS];
    t_flags r_flg [0:ITERS];

    logic signed [VZW-1:0]    n_zr;
    logic signed [HEAD_W-1:0] r_head;
    logic                     r_zd;

    assign en              = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    assign n_pf = fold(i_s_axis_tdata[AW-1:0]);
    assign n_rf = fold(i_s_axis_tdata[2*AW-1:AW]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ps[0]    <= '{x: ZW'(Q30_GAIN), y: '0, z: n_pf[ZW-1:0]};
            r_rs[0]    <= '{x: ZW'(Q30_GAIN), y: '0, z: n_rf[ZW-1:0]};
            r_pneg[0]  <= n_pf[ZW];
            r_rneg[0]  <= n_rf[ZW];
            r_mag[0].x <= i_s_axis_tdata[2*AW+SW-1:2*AW];
            r_mag[0].y <= i_s_axis_tdata[2*AW+2*SW-1:2*AW+SW];
            r_mag[0].z <= i_s_axis_tdata[2*AW+3*SW-1:2*AW+2*SW];
        end
    end

    for (genvar j = 1; j <= ITERS; j++) begin : g_sc
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ps[j]   <= sc_step(r_ps[j-1], j - 1, ATAN_TAB[j-1]);
                r_rs[j]   <= sc_step(r_rs[j-1], j - 1, ATAN_TAB[j-1]);
                r_pneg[j] <= r_pneg[j-1];
                r_rneg[j] <= r_rneg[j-1];
                r_mag[j]  <= r_mag[j-1];
            end
        end
    end

    // sign fix, sine products, sample products, xh/yh sums, vectoring setup
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cp    <= r_pneg[ITERS] ? -CSW'(r_ps[ITERS].x) : CSW'(r_ps[ITERS].x);
            r_sp    <= r_pneg[ITERS] ? -CSW'(r_ps[ITERS].y) : CSW'(r_ps[ITERS].y);
            r_cr    <= r_rneg[ITERS] ? -CSW'(r_rs[ITERS].x) : CSW'(r_rs[ITERS].x);
            r_sr    <= r_rneg[ITERS] ? -CSW'(r_rs[ITERS].y) : CSW'(r_rs[ITERS].y);
            r_mag_f <= r_mag[ITERS];

            r_srsp_p <= r_sr * r_sp;
            r_srcp_p <= r_sr * r_cp;
            r_cp1    <= r_cp;
            r_sp1    <= r_sp;
            r_cr1    <= r_cr;
            r_mag1   <= r_mag_f;

            r_pa <= r_mag1.x * r_cp1;
            r_pb <= r_mag1.z * r_sp1;
            r_pc <= r_mag1.x * n_srsp;
            r_pd <= r_mag1.y * r_cr1;
            r_pe <= r_mag1.z * n_srcp;

            r_xh <= VW'(r_pa) + VW'(r_pb);
            r_yh <= VW'(r_pc) + VW'(r_pd) - VW'(r_pe);

            // negative xh: flip both, ratio unchanged
            r_v[0].x      <= r_xh[VW-1] ? -r_xh : r_xh;
            r_v[0].y      <= r_xh[VW-1] ? -r_yh : r_yh;
            r_v[0].z      <= '0;
            r_flg[0].zf   <= (r_xh == '0);
            r_flg[0].ypos <= (r_yh > 0);
            r_flg[0].yneg <= r_yh[VW-1];
        end
    end

    assign n_srsp = CSW'(r_srsp_p >>> 30);
    assign n_srcp = CSW'(r_srcp_p >>> 30);

    for (genvar k = 1; k <= ITERS; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_v[k]   <= vec_step(r_v[k-1], k - 1, ATAN_TAB[k-1]);
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    assign n_zr = (r_v[ITERS].z + (VZW'(1) <<< (29 - ANGLE_FRAC_BITS)))
                  >>> (30 - ANGLE_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zd <= r_flg[ITERS].zf;
            if (!r_flg[ITERS].zf) begin
                r_head <= HEAD_W'(n_zr);
            end else if (r_flg[ITERS].ypos) begin
                r_head <= HHALF;
            end else if (r_flg[ITERS].yneg) begin
                r_head <= -HHALF;
            end else begin
                r_head <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = OUT_W'(unsigned'(r_head));
    assign o_m_axis_tuser  = r_zd;

    `TCH_ASSERT_MSG(a_zero_head, o_m_axis_tvalid && r_zd |-> (r_head == HHALF || r_head == -HHALF || r_head == '0), "zero divisor heading not +/-pi/2 or 0")
    `TCH_ASSERT_MSG(a_head_range, o_m_axis_tvalid |-> (r_head <= HMAX && r_head >= -HMAX), "heading beyond cordic range")
    `TCH_ASSERT(a_stall_hold, !en |=> $stable(r_vld))
endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb - tilt compensated heading testbench
// streams magnetometer samples with pitch and roll, predicts heading and the
// zero divisor flag with a bit-accurate cordic model, checks every output item
// ----------------------------------------------------------------------------
module tb
    import tch_pkg::*;
;
    typedef struct packed {
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] roll;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] my;
        logic signed [SW-1:0] mz;
    } t_sample;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic                     zdiv;
    } t_heading;

    localparam int ANG_MAX = 25736;
    localparam int QTR     = 12868;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tuser;

    t_sample  sample_q[$];
    t_heading heading_q[$];
    int       err_cnt = 0;
    int       cyc = 0;
    bit       fill_done = 0;

    tilt_compensated_heading_top u_top (.*);

    always #5 i_clk = ~i_clk;

    // q30 sine and cosine, folded by pi outside +/-pi/2
    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = Q30_GAIN;
        y = 0;
        flip = 0;
        if (ang > Q30_HALF_PI) begin
            ang -= Q30_PI;
            flip = 1;
        end else if (ang < -Q30_HALF_PI) begin
            ang += Q30_PI;
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vec_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint to_head(longint v);
        return (v + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
    endfunction

    function automatic t_heading predict_heading(t_sample smp);
        longint sp, cp, sr, cr, srsp, srcp, xh, yh, h;
        t_heading res;
        sin_cos(longint'(smp.pitch) <<< (30 - ANGLE_FRAC_BITS), sp, cp);
        sin_cos(longint'(smp.roll) <<< (30 - ANGLE_FRAC_BITS), sr, cr);
        srsp = (sr * sp) >>> 30;
        srcp = (sr * cp) >>> 30;
        xh = longint'(smp.mx) * cp + longint'(smp.mz) * sp;
        yh = longint'(smp.mx) * srsp + longint'(smp.my) * cr - longint'(smp.mz) * srcp;
        res.zdiv = (xh == 0);
        if (xh == 0) begin
            h = (yh > 0) ? to_head(Q30_HALF_PI) : (yh < 0) ? -to_head(Q30_HALF_PI) : 0;
        end else begin
            if (xh < 0) begin
                xh = -xh; yh = -yh;
            end
            h = to_head(vec_angle(xh, yh));
        end
        res.heading = h[HEAD_W-1:0];
        return res;
    endfunction

    task automatic add_sample(int p, int r, int x, int y, int z);
        t_sample smp;
        smp.pitch = AW'(p);
        smp.roll  = AW'(r);
        smp.mx    = SW'(x);
        smp.my    = SW'(y);
        smp.mz    = SW'(z);
        sample_q.push_back(smp);
    endtask

    function automatic int rand_angle();
        return int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    endfunction

    function automatic int rand_mag();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 16)) - 8;
            1: return ($urandom_range(0, 1)) ? 32767 : -32768;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic report(string what, int got, int exp_v);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp_v, cyc);
        err_cnt++;
    endtask

    // no idling on either side in this window
    function automatic bit idle_now();
        return !(cyc >= 500 && cyc < 1500) && ($urandom_range(0, 99) < 10);
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // driver
    always @(posedge i_clk) begin
        t_sample smp;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (sample_q.size() > 0 && !idle_now()) begin
                smp = sample_q.pop_front();
                heading_q.push_back(predict_heading(smp));
                i_s_axis_tdata  <= {smp.mz, smp.my, smp.mx, smp.roll, smp.pitch};
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_heading exp_h;
        if (i_rst_n) begin
            i_m_axis_tready <= !idle_now();
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (heading_q.size() == 0) begin
                    report("unexpected item", o_m_axis_tdata, 0);
                end else begin
                    exp_h = heading_q.pop_front();
                    if (o_m_axis_tdata !== OUT_W'(exp_h.heading & {HEAD_W{1'b1}}))
                        report("heading", $signed(o_m_axis_tdata[HEAD_W-1:0]),
                               exp_h.heading);
                    if (o_m_axis_tuser !== exp_h.zdiv)
                        report("zero_divisor", o_m_axis_tuser, exp_h.zdiv);
                end
            end
        end
    end

    initial begin
        int angs[8];
        angs = '{0, QTR, -QTR, QTR + 1, -QTR - 1, ANG_MAX, -ANG_MAX, 8192};
        foreach (angs[k]) add_sample(angs[k], angs[7 - k], 32767, -32768, 32767);
        add_sample(ANG_MAX, -ANG_MAX, -32768, 32767, -32768);
        add_sample(0, 0, -1000, 500, 0);         // negative xh
        add_sample(0, 0, 0, 1234, 0);            // zero xh, yh positive
        add_sample(0, 0, 0, -1234, 0);           // zero xh, yh negative
        add_sample(0, 0, 0, 0, 0);               // zero xh and yh
        add_sample(4000, -7000, 0, 0, 0);
        add_sample(0, 0, 1, -1, 0);
        add_sample(-QTR, QTR, -1, 1, -1);
        add_sample(3, -3, 32767, 32767, -32768);
        for (int n = 0; n < 2000; n++) begin
            if ($urandom_range(0, 9) == 0)
                add_sample(rand_angle(), rand_angle(), 0, rand_mag(), 0);
            else
                add_sample(rand_angle(), rand_angle(), rand_mag(), rand_mag(), rand_mag());
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fill_done = 1;
    end

    initial begin
        wait (fill_done);
        while (sample_q.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        while (heading_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
